FILE: rtl/lkv_pkg.sv
// shared types and constants of the lru key-value cache
// depends on nothing; used by every file in rtl
package lkv_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int CFG_W = 5;
   localparam int OCC_W = 5;
   localparam int KEY_W = 32;
   localparam int VALUE_W = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                      operation;
      logic signed [KEY_W-1:0]   lookup_key;
      logic        [VALUE_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic               is_put;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } work_type;

endpackage

FILE: rtl/lru_key_value_cache.sv
// top level of the lru key-value cache: capacity register and the three stages
// depends on lkv_pkg, lkv_front, lkv_back, lkv_rsp_queue

// Fully associative key-value cache with least-recently-used replacement. Requests
// (get or put) enter a two-entry request queue; the execution engine takes one request
// at a time: first all keys are compared in parallel and the valid, recency and key
// state is updated while the value memory is read or written, then the registered
// value read is formed into a result and pushed into a two-entry response queue. The
// engine takes no new request until it has pushed the result of the last one; with the
// engine idle and room in the response queue, a request passes the request queue, the
// engine's result registers and the response queue before its result is on the rsp
// ports. A full response queue holds the engine, and a full request queue holds the
// input. No clearing pass is needed after reset. A capacity write applies to requests
// that the engine starts after it, so write it only while no request is in flight;
// csr_ready is always high.
module lru_key_value_cache #(
   parameter int CAPACITY = lkv_pkg::CAPACITY_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  lkv_pkg::req_type          req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output lkv_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lkv_pkg::CFG_W-1:0] csr_data
);

   logic [lkv_pkg::CFG_W-1:0] cap_ff, cap_in;
   logic work_valid, work_take, rsp_full, rsp_push;
   lkv_pkg::work_type work;
   lkv_pkg::rsp_type rsp_item;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lkv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_take  (work_take),
      .work       (work)
   );

   lkv_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (cap_ff),
      .work_valid (work_valid),
      .work_take  (work_take),
      .work       (work),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item)
   );

   lkv_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .full      (rsp_full),
      .push_item (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/lkv_front.sv
// request front end: accepts requests, decodes them and holds them in a short queue
// depends on lkv_pkg
module lkv_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  lkv_pkg::req_type  req_data,
   output logic              work_valid,
   input  logic              work_take,
   output lkv_pkg::work_type work
);

   localparam int PW = lkv_pkg::QPTR_W;
   localparam int CW = lkv_pkg::QCNT_W;

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   lkv_pkg::work_type slot_ff [lkv_pkg::QUEUE_DEPTH];
   lkv_pkg::work_type decoded;
   logic do_push, do_pop;

   assign req_full   = (cnt_ff == CW'(lkv_pkg::QUEUE_DEPTH));
   assign work_valid = (cnt_ff != '0);
   assign work       = slot_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = work_take && work_valid;

   always_comb begin
      decoded.is_put = (req_data.operation == lkv_pkg::OP_PUT);
      decoded.key    = $unsigned(req_data.lookup_key);
      decoded.value  = req_data.write_value;
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: rtl/lkv_rsp_queue.sv
// response queue: holds finished results until the consumer takes them
// depends on lkv_pkg
module lkv_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  lkv_pkg::rsp_type push_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output lkv_pkg::rsp_type rsp_data
);

   localparam int PW = lkv_pkg::QPTR_W;
   localparam int CW = lkv_pkg::QCNT_W;

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   lkv_pkg::rsp_type slot_ff [lkv_pkg::QUEUE_DEPTH];
   logic do_push, do_pop;

   assign full      = (cnt_ff == CW'(lkv_pkg::QUEUE_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/lkv_back.sv
// execution engine: parallel key match, recency update, eviction and value memory
// depends on lkv_pkg; fed by lkv_front, drains into lkv_rsp_queue
module lkv_back #(
   parameter int CAPACITY = lkv_pkg::CAPACITY_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lkv_pkg::CFG_W-1:0] capacity,
   input  logic                      work_valid,
   output logic                      work_take,
   input  lkv_pkg::work_type         work,
   input  logic                      rsp_full,
   output logic                      rsp_push,
   output lkv_pkg::rsp_type          rsp_item
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW = $clog2(CAPACITY + 1);
   localparam int OW = lkv_pkg::OCC_W;

   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [IW-1:0] rank_ff [CAPACITY];
   logic [IW-1:0] rank_in [CAPACITY];
   logic [lkv_pkg::KEY_W-1:0] key_ff [CAPACITY];
   logic [lkv_pkg::VALUE_W-1:0] value_mem [CAPACITY];
   logic [NW-1:0] count_ff, count_in;
   logic phase_ff;
   logic found_ff, put_ff;
   logic [OW-1:0] occ_ff;
   logic [lkv_pkg::VALUE_W-1:0] rdata_ff;

   logic go, any_hit, do_evict, do_insert;
   logic [CAPACITY-1:0] hit_vec, victim_vec, free_vec;
   logic [IW-1:0] hit_idx, hit_rank, ins_idx, mem_addr;
   logic [NW-1:0] eff_cap;

   assign go        = !phase_ff && work_valid && !rsp_full;
   assign work_take = go;
   assign mem_addr  = any_hit ? hit_idx : ins_idx;

   always_comb begin
      if (capacity == '0) begin
         eff_cap = NW'(1);
      end else if (32'(capacity) > 32'(CAPACITY)) begin
         eff_cap = NW'(CAPACITY);
      end else begin
         eff_cap = NW'(capacity);
      end
   end

   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == work.key);
         hit_idx  = hit_idx | (hit_vec[i] ? IW'(i) : '0);
         hit_rank = hit_rank | (hit_vec[i] ? rank_ff[i] : '0);
      end
      any_hit   = |hit_vec;
      do_insert = work.is_put && !any_hit;
      do_evict  = do_insert && (32'(count_ff) >= 32'(eff_cap));
      for (int i = 0; i < CAPACITY; i++) begin
         victim_vec[i] = do_evict && valid_ff[i]
                         && (32'(rank_ff[i]) == 32'(count_ff) - 32'd1);
      end
      free_vec = ~valid_ff | victim_vec;
      ins_idx  = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            ins_idx = IW'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (go && any_hit) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (hit_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end
      end else if (go && do_insert) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i] && !victim_vec[i]) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
            if (IW'(i) == ins_idx) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (victim_vec[i]) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end
         end
         count_in = count_ff + NW'(1) - NW'(do_evict);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         phase_ff <= go;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         found_ff <= any_hit;
         put_ff   <= work.is_put;
         occ_ff   <= OW'(count_in);
         rdata_ff <= value_mem[mem_addr];
         if (work.is_put) begin
            value_mem[mem_addr] <= work.value;
         end
         if (do_insert) begin
            key_ff[ins_idx] <= work.key;
         end
      end
   end

   always_comb begin
      rsp_push            = phase_ff;
      rsp_item.found      = found_ff;
      rsp_item.read_value = (found_ff && !put_ff) ? rdata_ff : '0;
      rsp_item.occupancy  = occ_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count out of step with valid entries");

   assert property (@(posedge clock) disable iff (reset)
      go |-> $onehot0(hit_vec))
      else $error("key matched in more than one entry");

   assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_push && !rsp_full)
      else $error("result could not be pushed after start");

   assert property (@(posedge clock) disable iff (reset)
      (go && do_evict) |-> $onehot(victim_vec))
      else $error("eviction without a unique least recent entry");

endmodule

FILE: sim/lru_key_value_cache_tb.sv
// testbench of the lru key-value cache: queued get/put traffic against an in-bench lru predictor
// depends on lkv_pkg and lru_key_value_cache from rtl
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

   localparam int SLOTS = lkv_pkg::CAPACITY_DEFAULT;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   lkv_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   lkv_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [lkv_pkg::CFG_W-1:0] csr_data = '0;

   // predictor state
   logic [lkv_pkg::KEY_W-1:0]   cache_key [SLOTS];
   logic [lkv_pkg::VALUE_W-1:0] cache_val [SLOTS];
   bit                          cache_vld [SLOTS];
   int                          cache_rank [SLOTS];
   int                          cache_count = 0;
   int                          cache_cap = 16;

   lkv_pkg::req_type pending_reqs [$];
   lkv_pkg::rsp_type expected_rsps [$];
   lkv_pkg::rsp_type want;
   int      accepted_reqs = 0;
   int      accepted_rsps = 0;
   int      hold_left = 0;
   int      errors = 0;
   logic [lkv_pkg::KEY_W-1:0] key_pool [0:63];

   lru_key_value_cache u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         cache_vld[i] = 1'b0;
         cache_rank[i] = 0;
      end
   end

   function automatic lkv_pkg::rsp_type lru_access(input lkv_pkg::req_type r);
      lkv_pkg::rsp_type o;
      int hit, victim, best, slot, eff;
      o = '0;
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && cache_vld[i] && cache_key[i] == r.lookup_key)
            hit = i;
      if (hit >= 0) begin
         o.found = 1'b1;
         if (r.operation == lkv_pkg::OP_PUT)
            cache_val[hit] = r.write_value;
         else
            o.read_value = cache_val[hit];
         for (int i = 0; i < SLOTS; i++)
            if (cache_vld[i] && cache_rank[i] < cache_rank[hit])
               cache_rank[i]++;
         cache_rank[hit] = 0;
      end else if (r.operation == lkv_pkg::OP_PUT) begin
         eff = cache_cap;
         if (eff < 1)
            eff = 1;
         if (eff > SLOTS)
            eff = SLOTS;
         if (cache_count >= eff) begin
            victim = -1;
            best = 0;
            for (int i = 0; i < SLOTS; i++)
               if (cache_vld[i] && (victim < 0 || cache_rank[i] >= best)) begin
                  best = cache_rank[i];
                  victim = i;
               end
            if (victim >= 0) begin
               cache_vld[victim] = 1'b0;
               cache_rank[victim] = 0;
               cache_count--;
            end
         end
         slot = -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !cache_vld[i])
               slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (cache_vld[i])
                  cache_rank[i]++;
            cache_key[slot] = r.lookup_key;
            cache_val[slot] = r.write_value;
            cache_vld[slot] = 1'b1;
            cache_rank[slot] = 0;
            cache_count++;
         end
      end
      o.occupancy = cache_count[lkv_pkg::OCC_W-1:0];
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_push && !req_full) begin
            expected_rsps.push_back(lru_access(req_data));
            void'(pending_reqs.pop_front());
            accepted_reqs = accepted_reqs + 1;
         end
         if (pending_reqs.size() != 0 &&
             ((accepted_reqs >= 500 && accepted_reqs < 800) || $urandom_range(99) >= 14)) begin
            req_push <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               errors = errors + 1;
               $display("%0t result transfer: expected none actual %h", $time, rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.found !== want.found) begin
                  errors = errors + 1;
                  $display("%0t found: expected %0b actual %0b", $time,
                           want.found, rsp_data.found);
               end
               if (rsp_data.read_value !== want.read_value) begin
                  errors = errors + 1;
                  $display("%0t read_value: expected %h actual %h", $time,
                           want.read_value, rsp_data.read_value);
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  errors = errors + 1;
                  $display("%0t occupancy: expected %0d actual %0d", $time,
                           want.occupancy, rsp_data.occupancy);
               end
            end
            accepted_rsps = accepted_rsps + 1;
            if (accepted_rsps == 100 || accepted_rsps == 900)
               hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= (accepted_reqs >= 500 && accepted_reqs < 800) || $urandom_range(99) >= 14;
         end
      end
   end

   task automatic queue_request(input logic op, input logic [lkv_pkg::KEY_W-1:0] key,
                                input logic [lkv_pkg::VALUE_W-1:0] value);
      lkv_pkg::req_type r;
      r.operation = op;
      r.lookup_key = key;
      r.write_value = value;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_random(input int count, input int pool_n);
      logic [lkv_pkg::KEY_W-1:0] key;
      for (int i = 0; i < pool_n; i++)
         key_pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(pool_n - 1)];
         else
            key = $urandom;
         queue_request(1'($urandom_range(1)), key, {$urandom, $urandom});
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lkv_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      cache_cap = int'(value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cache, one key
      queue_request(lkv_pkg::OP_GET, 32'h0000_0000, 64'h0);
      queue_request(lkv_pkg::OP_PUT, 32'h1357_9bdf, 64'hffff_ffff_ffff_ffff);
      queue_request(lkv_pkg::OP_GET, 32'h1357_9bdf, 64'h0);
      queue_request(lkv_pkg::OP_PUT, 32'h1357_9bdf, 64'h0123_4567_89ab_cdef);
      drain();

      // capacity zero acts as one
      write_capacity(5'd0);
      queue_request(lkv_pkg::OP_PUT, 32'h2468_ace0, 64'h0);
      queue_request(lkv_pkg::OP_GET, 32'h1357_9bdf, 64'hffff_ffff_ffff_ffff);
      queue_request(lkv_pkg::OP_GET, 32'h2468_ace0, 64'h0);
      queue_random(100, 3);
      drain();

      // recency decides the victim
      write_capacity(5'd2);
      queue_request(lkv_pkg::OP_PUT, 32'h0bad_f00d, 64'h1111_2222_3333_4444);
      queue_request(lkv_pkg::OP_GET, 32'h2468_ace0, 64'h0);
      queue_request(lkv_pkg::OP_PUT, 32'h0000_0000, 64'h5555_5555_5555_5555);
      queue_request(lkv_pkg::OP_GET, 32'h0bad_f00d, 64'h0);
      queue_request(lkv_pkg::OP_GET, 32'h2468_ace0, 64'h0);
      queue_request(lkv_pkg::OP_GET, 32'h0000_0000, 64'h0);
      drain();
      queue_random(150, 5);
      drain();

      write_capacity(5'd3);
      queue_random(150, 6);
      drain();

      write_capacity(5'd5);
      queue_random(150, 8);
      drain();

      // above the slot count saturates; extreme keys
      write_capacity(5'd31);
      queue_request(lkv_pkg::OP_PUT, 32'h8000_0000, 64'hffff_ffff_ffff_ffff);
      queue_request(lkv_pkg::OP_PUT, 32'h7fff_ffff, 64'h0);
      queue_request(lkv_pkg::OP_PUT, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
      queue_request(lkv_pkg::OP_GET, 32'h8000_0000, 64'h0);
      queue_request(lkv_pkg::OP_GET, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
      queue_request(lkv_pkg::OP_GET, 32'hffff_ffff, 64'h0);
      queue_random(200, 24);
      drain();

      // lowered below the occupancy
      write_capacity(5'd3);
      queue_random(200, 20);
      drain();

      write_capacity(5'd17);
      queue_random(200, 40);
      drain();

      write_capacity(5'd1);
      queue_random(100, 4);
      drain();

      write_capacity(5'd16);
      queue_random(150, 18);
      drain();

      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
